// File: rtl/ekct_pkg.sv
// ----------------------------------------------------------------------------
// ekct_pkg: shared types and codes for the epoch keyed checkpoint table
// Field widths, operation and status codes, sequencer states and the result
// of the shared comparator.
// ----------------------------------------------------------------------------
package ekct_pkg;

    localparam int EPOCH_W   = 64;
    localparam int PAYLOAD_W = 64;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_LATEST = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_UNVERIFIED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH_READ,
        ST_MATCH_CMP,
        ST_MIN_READ,
        ST_MIN_CMP,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic eq;
        logic lt;
    } cmp_res_t;

endpackage

// File: rtl/ekct_cmp.sv
// ----------------------------------------------------------------------------
// ekct_cmp: shared epoch comparator
// One unsigned 64-bit compare giving equality and less-than of a against b.
// ----------------------------------------------------------------------------
module ekct_cmp
    import ekct_pkg::*;
(
    input  logic [EPOCH_W-1:0] a,
    input  logic [EPOCH_W-1:0] b,
    output cmp_res_t           res
);

    always_comb
    begin
        res.eq = (a == b);
        res.lt = (a < b);
    end

endmodule

// File: rtl/ekct_mem.sv
// ----------------------------------------------------------------------------
// ekct_mem: slot storage
// Epoch and payload per slot, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ekct_mem
    import ekct_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
)
(
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  logic [EPOCH_W-1:0]   wr_epoch,
    input  logic [PAYLOAD_W-1:0] wr_payload,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output logic [EPOCH_W-1:0]   rd_epoch,
    output logic [PAYLOAD_W-1:0] rd_payload
);

    logic [EPOCH_W-1:0]   epoch_mem   [DEPTH];
    logic [PAYLOAD_W-1:0] payload_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            epoch_mem[wr_addr]   <= wr_epoch;
            payload_mem[wr_addr] <= wr_payload;
        end
        if (rd_en)
        begin
            rd_epoch   <= epoch_mem[rd_addr];
            rd_payload <= payload_mem[rd_addr];
        end
    end

endmodule

// File: rtl/epoch_keyed_checkpoint_table.sv
// ----------------------------------------------------------------------------
// epoch_keyed_checkpoint_table: bounded checkpoint store keyed by epoch
// Insert, look up by epoch and get-latest over a slot memory, scanned one
// slot at a time through a single shared comparator.
// ----------------------------------------------------------------------------
// One beat is taken at a time; in_stall stays high until its result has
// moved into the output register. Every slot visited is a memory read
// then a compare in the one shared comparator. An insert into a full
// table that misses runs a second scan for the smallest epoch. A
// rejected insert, an unused op or a query on an empty table goes
// straight to completion without a scan. The slot memory needs no
// clearing after reset.
// ----------------------------------------------------------------------------
module epoch_keyed_checkpoint_table
    import ekct_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [OP_W-1:0]      op,
    input  logic [EPOCH_W-1:0]   key_epoch,
    input  logic [PAYLOAD_W-1:0] entry_payload,
    input  logic                 verified,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [STATUS_W-1:0]  status,
    output logic [EPOCH_W-1:0]   found_epoch,
    output logic [PAYLOAD_W-1:0] found_payload
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    state_t state_reg, state_next;

    logic [OP_W-1:0]      op_reg, op_next;
    logic [EPOCH_W-1:0]   key_reg, key_next;
    logic [PAYLOAD_W-1:0] pay_reg, pay_next;
    logic [EPOCH_W-1:0]   want_reg, want_next;
    logic [IDX_W-1:0]     scan_reg, scan_next;
    logic [IDX_W-1:0]     widx_reg, widx_next;
    logic                 grow_reg, grow_next;
    logic [EPOCH_W-1:0]   min_reg, min_next;
    logic [CNT_W-1:0]     used_reg, used_next;
    logic [EPOCH_W-1:0]   highest_reg, highest_next;

    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [EPOCH_W-1:0]   res_epoch_reg, res_epoch_next;
    logic [PAYLOAD_W-1:0] res_payload_reg, res_payload_next;

    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [EPOCH_W-1:0]   found_epoch_reg, found_epoch_next;
    logic [PAYLOAD_W-1:0] found_payload_reg, found_payload_next;

    logic                 accept;
    logic                 out_free;
    logic                 is_last;
    logic                 full;
    logic                 is_insert;

    logic                 mem_rd_en;
    logic                 mem_wr_en;
    logic [EPOCH_W-1:0]   rd_epoch;
    logic [PAYLOAD_W-1:0] rd_payload;

    logic [EPOCH_W-1:0]   cmp_a;
    logic [EPOCH_W-1:0]   cmp_b;
    cmp_res_t             cmp_res;

    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign is_last   = ((CNT_W'(scan_reg) + CNT_W'(1)) == used_reg);
    assign full      = (used_reg == CNT_W'(TABLE_DEPTH));
    assign is_insert = (op_reg == OP_INSERT);

    ekct_cmp u_cmp
    (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_res)
    );

    ekct_mem #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (IDX_W)
    ) u_mem
    (
        .clk        (clk),
        .wr_en      (mem_wr_en),
        .wr_addr    (widx_reg),
        .wr_epoch   (key_reg),
        .wr_payload (pay_reg),
        .rd_en      (mem_rd_en),
        .rd_addr    (scan_reg),
        .rd_epoch   (rd_epoch),
        .rd_payload (rd_payload)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (op)
                        OP_INSERT:
                        begin
                            if (!verified)
                                state_next = ST_DONE;
                            else if (used_reg == '0)
                                state_next = ST_WRITE;
                            else
                                state_next = ST_MATCH_READ;
                        end
                        OP_LOOKUP, OP_LATEST:
                            state_next = (used_reg == '0) ? ST_DONE : ST_MATCH_READ;
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_MATCH_READ:
                state_next = ST_MATCH_CMP;
            ST_MATCH_CMP:
            begin
                if (cmp_res.eq)
                    state_next = is_insert ? ST_WRITE : ST_DONE;
                else if (is_last)
                begin
                    if (!is_insert)
                        state_next = ST_DONE;
                    else
                        state_next = full ? ST_MIN_READ : ST_WRITE;
                end
                else
                    state_next = ST_MATCH_READ;
            end
            ST_MIN_READ:
                state_next = ST_MIN_CMP;
            ST_MIN_CMP:
                state_next = is_last ? ST_WRITE : ST_MIN_READ;
            ST_WRITE:
                state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs and unit controls
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        mem_rd_en = 1'b0;
        mem_wr_en = 1'b0;
        cmp_a     = rd_epoch;
        cmp_b     = want_reg;
        case (state_reg)
            ST_MATCH_READ, ST_MIN_READ:
                mem_rd_en = 1'b1;
            ST_MIN_CMP:
                cmp_b = min_reg;
            ST_WRITE:
            begin
                mem_wr_en = 1'b1;
                cmp_a     = highest_reg;
                cmp_b     = key_reg;
            end
            default:
                mem_rd_en = 1'b0;
        endcase
    end

    // datapath
    always_comb
    begin
        op_next            = op_reg;
        key_next           = key_reg;
        pay_next           = pay_reg;
        want_next          = want_reg;
        scan_next          = scan_reg;
        widx_next          = widx_reg;
        grow_next          = grow_reg;
        min_next           = min_reg;
        used_next          = used_reg;
        highest_next       = highest_reg;
        res_status_next    = res_status_reg;
        res_epoch_next     = res_epoch_reg;
        res_payload_next   = res_payload_reg;
        out_valid_next     = out_valid_reg && out_stall;
        status_next        = status_reg;
        found_epoch_next   = found_epoch_reg;
        found_payload_next = found_payload_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next          = op;
                    key_next         = key_epoch;
                    pay_next         = entry_payload;
                    want_next        = (op == OP_LATEST) ? highest_reg : key_epoch;
                    scan_next        = '0;
                    widx_next        = '0;
                    grow_next        = 1'b1;
                    res_epoch_next   = '0;
                    res_payload_next = '0;
                    if (op == OP_INSERT)
                        res_status_next = verified ? STATUS_OK : STATUS_UNVERIFIED;
                    else
                        res_status_next = STATUS_NOT_FOUND;
                end
            end
            ST_MATCH_CMP:
            begin
                if (cmp_res.eq)
                begin
                    widx_next = scan_reg;
                    grow_next = 1'b0;
                    if (!is_insert)
                    begin
                        res_status_next  = STATUS_OK;
                        res_epoch_next   = rd_epoch;
                        res_payload_next = rd_payload;
                    end
                end
                else if (is_last)
                begin
                    if (full)
                    begin
                        scan_next = '0;
                        grow_next = 1'b0;
                    end
                    else
                    begin
                        widx_next = used_reg[IDX_W-1:0];
                        grow_next = 1'b1;
                    end
                end
                else
                    scan_next = scan_reg + IDX_W'(1);
            end
            ST_MIN_CMP:
            begin
                if ((scan_reg == '0) || cmp_res.lt)
                begin
                    min_next  = rd_epoch;
                    widx_next = scan_reg;
                end
                if (!is_last)
                    scan_next = scan_reg + IDX_W'(1);
            end
            ST_WRITE:
            begin
                if (grow_reg)
                    used_next = used_reg + CNT_W'(1);
                if (cmp_res.lt)
                    highest_next = key_reg;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    status_next        = res_status_reg;
                    found_epoch_next   = res_epoch_reg;
                    found_payload_next = res_payload_reg;
                end
            end
            default:
                scan_next = scan_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            highest_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            highest_reg   <= highest_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg            <= op_next;
        key_reg           <= key_next;
        pay_reg           <= pay_next;
        want_reg          <= want_next;
        scan_reg          <= scan_next;
        widx_reg          <= widx_next;
        grow_reg          <= grow_next;
        min_reg           <= min_next;
        res_status_reg    <= res_status_next;
        res_epoch_reg     <= res_epoch_next;
        res_payload_reg   <= res_payload_next;
        status_reg        <= status_next;
        found_epoch_reg   <= found_epoch_next;
        found_payload_reg <= found_payload_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign found_epoch   = found_epoch_reg;
    assign found_payload = found_payload_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(TABLE_DEPTH))
        else $error("slot count exceeds table depth");

    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != $past(used_reg)) |->
            ($past(state_reg) == ST_WRITE) && (used_reg == $past(used_reg) + CNT_W'(1)))
        else $error("slot count changed outside a write");

    a_highest_mono: assert property (@(posedge clk) disable iff (!rst_n)
        highest_reg >= $past(highest_reg))
        else $error("running maximum epoch decreased");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result beat raised outside completion");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("accepted beat did not start work");

endmodule
